### hw/rtl/rls_pkg.sv
// ============================================================================
// rls_pkg - shared types and constants for the RGB LED strip serializer
// Item and result beats, store access, send engine control and status.
// ============================================================================
package rls_pkg;

    // Store geometry
    localparam int MAX_LEDS  = 256;
    localparam int ADDR_W    = $clog2(MAX_LEDS);
    localparam int CNT_W     = $clog2(MAX_LEDS + 1);
    localparam int COLOR_W   = 8;
    localparam int ENTRY_W   = 3 * COLOR_W;
    localparam int BITPOS_W  = $clog2(ENTRY_W);
    localparam int TICK_W    = 8;
    localparam int LATCH_W   = 20;

    // Field widths of the beats
    localparam int OP_W      = 3;
    localparam int INDEX_W   = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_SHOW  = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = LATCH_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH       = 3'd4;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0]   RST_ACTIVE_LEDS = '0;
    localparam logic [TICK_W-1:0]  RST_ONE_HIGH    = 8'd12;
    localparam logic [TICK_W-1:0]  RST_ZERO_HIGH   = 8'd6;
    localparam logic [TICK_W-1:0]  RST_BIT_PERIOD  = 8'd24;
    localparam logic [LATCH_W-1:0] RST_LATCH       = 20'd20000;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] pixel_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_item;

    typedef struct packed {
        logic               line_level;
        logic               busy_res;
        logic               read_ok;
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]   active_leds;
        logic [TICK_W-1:0]  one_high;
        logic [TICK_W-1:0]  zero_high;
        logic [TICK_W-1:0]  bit_period;
        logic [LATCH_W-1:0] latch;
    } t_cfg;

    // Store write request
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } t_store_wr;

    // Send engine control
    typedef struct packed {
        logic tick;
        logic load;
    } t_send_cmd;

    // Send engine status
    typedef struct packed {
        logic             busy;
        logic             line;
        logic [CNT_W-1:0] ptr;
    } t_send_stat;

endpackage

### hw/rtl/rgb_led_strip_serializer.sv
// ============================================================================
// rgb_led_strip_serializer - addressable RGB LED chain driver (GRB order)
// Pixel store, command sequencer and bit-serial one-wire waveform engine.
// ============================================================================
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+------------------------
//  command   | in        | start high, busy low        | i_item  (t_item)
//  result    | out       | o_result_valid, one cycle   | o_result (t_result)
//  config    | in        | i_cfg_valid & o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  Timing: most ops return their beat the cycle after acceptance, so ticks
//  can be fed back to back. Read, and a show that starts a frame, hold busy
//  in S_READ or S_SHOW for a registered store read, which delays their beat.
//  A fill or clear that takes effect then sweeps the write port one entry a
//  cycle, up to the clamped LED count, with busy high.
//  Reset is synchronous, active low; entry valid bits make the whole store
//  read as zero right after reset, so there is no clearing pass.
//  The receiver cannot stall: each result beat lives for exactly one cycle.
//
module rgb_led_strip_serializer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  rls_pkg::t_item                   i_item,
    output logic                             o_result_valid,
    output rls_pkg::t_result                 o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SHOW  = 4'b0100,
        S_SWEEP = 4'b1000
    } t_state;

    localparam logic [CNT_W-1:0] LED_LIMIT = CNT_W'(MAX_LEDS);

    t_state             r_state, n_state;
    t_cfg               r_cfg;
    logic               r_res_valid, n_res_valid;
    logic               r_rd_ok,     n_rd_ok;
    logic [ENTRY_W-1:0] r_rd_word,   n_rd_word;
    logic               r_rd_hit,    n_rd_hit;
    logic [ADDR_W-1:0]  r_sweep_ptr, n_sweep_ptr;
    logic [ENTRY_W-1:0] r_sweep_data, n_sweep_data;

    logic               accept;
    logic [CNT_W-1:0]   count;
    logic               idx_hit;
    logic [ENTRY_W-1:0] colour;
    logic [ADDR_W-1:0]  fetch_addr;
    logic [ENTRY_W-1:0] rd_a_data;
    logic [ENTRY_W-1:0] rd_b_data;
    t_store_wr          store_wr;
    t_send_cmd          send_cmd;
    t_send_stat         send_stat;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start & ~busy;
    assign o_cfg_ready = (r_state == S_IDLE);

    // LED count clamped to the store depth
    assign count   = (r_cfg.active_leds > LED_LIMIT) ? LED_LIMIT : r_cfg.active_leds;
    assign idx_hit = ({1'b0, i_item.pixel_index} < count);
    assign colour  = {i_item.green, i_item.red, i_item.blue};

    // Port B follows the engine: entry 0 while idle, the next entry while sending
    assign fetch_addr = send_stat.busy ? (send_stat.ptr[ADDR_W-1:0] + ADDR_W'(1))
                                       : '0;

    rls_pixel_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (store_wr),
        .i_addr_a (i_item.pixel_index),
        .i_addr_b (fetch_addr),
        .o_data_a (rd_a_data),
        .o_data_b (rd_b_data)
    );

    rls_bit_shifter u_shifter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (send_cmd),
        .i_cfg   (r_cfg),
        .i_count (count),
        .i_word  (rd_b_data),
        .o_stat  (send_stat)
    );

    // Command sequencer
    always_comb begin
        n_state      = r_state;
        n_res_valid  = 1'b0;
        n_rd_ok      = r_rd_ok;
        n_rd_word    = r_rd_word;
        n_rd_hit     = r_rd_hit;
        n_sweep_ptr  = r_sweep_ptr;
        n_sweep_data = r_sweep_data;
        store_wr     = '0;
        send_cmd     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // default: beat goes out next cycle with no read data
                    n_res_valid = 1'b1;
                    n_rd_ok     = 1'b0;
                    n_rd_word   = '0;
                    case (i_item.op)
                        OP_WRITE: begin
                            store_wr.en   = ~send_stat.busy & idx_hit;
                            store_wr.addr = i_item.pixel_index;
                            store_wr.data = colour;
                        end
                        OP_READ: begin
                            n_res_valid = 1'b0;
                            n_rd_hit    = idx_hit;
                            n_state     = S_READ;
                        end
                        OP_FILL, OP_CLEAR: begin
                            if (!send_stat.busy && count != '0) begin
                                n_sweep_ptr  = '0;
                                n_sweep_data = (i_item.op == OP_FILL) ? colour : '0;
                                n_state      = S_SWEEP;
                            end
                        end
                        OP_SHOW: begin
                            if (!send_stat.busy) begin
                                n_res_valid = 1'b0;
                                n_state     = S_SHOW;
                            end
                        end
                        OP_TICK: begin
                            send_cmd.tick = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_valid = 1'b1;
                n_rd_ok     = r_rd_hit;
                n_rd_word   = r_rd_hit ? rd_a_data : '0;
                n_state     = S_IDLE;
            end
            S_SHOW: begin
                // port B has held entry 0 since the show beat was taken
                send_cmd.load = 1'b1;
                n_res_valid   = 1'b1;
                n_rd_ok       = 1'b0;
                n_rd_word     = '0;
                n_state       = S_IDLE;
            end
            S_SWEEP: begin
                store_wr.en   = 1'b1;
                store_wr.addr = r_sweep_ptr;
                store_wr.data = r_sweep_data;
                if (({1'b0, r_sweep_ptr} + CNT_W'(1)) == count) begin
                    n_state = S_IDLE;
                end else begin
                    n_sweep_ptr = r_sweep_ptr + ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_rd_word   <= '0;
            r_rd_hit    <= 1'b0;
            r_sweep_ptr <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_rd_ok     <= n_rd_ok;
            r_rd_word   <= n_rd_word;
            r_rd_hit    <= n_rd_hit;
            r_sweep_ptr <= n_sweep_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sweep_data <= n_sweep_data;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_leds <= RST_ACTIVE_LEDS;
            r_cfg.one_high    <= RST_ONE_HIGH;
            r_cfg.zero_high   <= RST_ZERO_HIGH;
            r_cfg.bit_period  <= RST_BIT_PERIOD;
            r_cfg.latch       <= RST_LATCH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ACTIVE_LEDS: r_cfg.active_leds <= i_cfg_data[CNT_W-1:0];
                CFG_ONE_HIGH:    r_cfg.one_high    <= i_cfg_data[TICK_W-1:0];
                CFG_ZERO_HIGH:   r_cfg.zero_high   <= i_cfg_data[TICK_W-1:0];
                CFG_BIT_PERIOD:  r_cfg.bit_period  <= i_cfg_data[TICK_W-1:0];
                CFG_LATCH:       r_cfg.latch       <= i_cfg_data[LATCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Result beat: line and busy come straight from the engine registers,
    // which already show the state after the item
    assign o_result_valid       = r_res_valid;
    assign o_result.line_level  = send_stat.line;
    assign o_result.busy_res    = send_stat.busy;
    assign o_result.read_ok     = r_rd_ok;
    assign o_result.green_out   = r_rd_word[3*COLOR_W-1:2*COLOR_W];
    assign o_result.red_out     = r_rd_word[2*COLOR_W-1:COLOR_W];
    assign o_result.blue_out    = r_rd_word[COLOR_W-1:0];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.op == OP_READ) |=> (!o_result_valid ##1 o_result_valid))
        else $error("read beat not returned two cycles after acceptance");

    a_quick_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.op != OP_READ && i_item.op != OP_SHOW) |=> o_result_valid)
        else $error("single-cycle item did not return its beat");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.read_ok) |->
        (o_result.red_out == '0 && o_result.green_out == '0 && o_result.blue_out == '0))
        else $error("colour returned without a read hit");

    a_line_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        send_stat.line |-> send_stat.busy)
        else $error("data line high outside a frame");

    a_sweep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !send_stat.busy)
        else $error("store sweep overlaps a frame");

endmodule

### hw/rtl/rls_pixel_store.sv
// ============================================================================
// rls_pixel_store - colour entry memory
// One write port, two registered read ports; per-entry valid bits make
// never-written entries read as zero after reset.
// ============================================================================
module rls_pixel_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rls_pkg::t_store_wr             i_wr,
    input  logic [rls_pkg::ADDR_W-1:0]     i_addr_a,
    input  logic [rls_pkg::ADDR_W-1:0]     i_addr_b,
    output logic [rls_pkg::ENTRY_W-1:0]    o_data_a,
    output logic [rls_pkg::ENTRY_W-1:0]    o_data_b
);
    import rls_pkg::*;

    logic [ENTRY_W-1:0] r_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] r_valid;
    logic [ENTRY_W-1:0] r_data_a;
    logic [ENTRY_W-1:0] r_data_b;
    logic               r_valid_a;
    logic               r_valid_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_data_a <= r_mem[i_addr_a];
        r_data_b <= r_mem[i_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_valid_a <= r_valid[i_addr_a];
            r_valid_b <= r_valid[i_addr_b];
        end
    end

    assign o_data_a = r_valid_a ? r_data_a : '0;
    assign o_data_b = r_valid_b ? r_data_b : '0;

endmodule

### hw/rtl/rls_bit_shifter.sv
// ============================================================================
// rls_bit_shifter - one-wire waveform engine
// Shifts each entry out MSB first, one bit cell per bit_period ticks,
// then holds the line low for the latch gap.
// ============================================================================
module rls_bit_shifter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rls_pkg::t_send_cmd            i_cmd,
    input  rls_pkg::t_cfg                 i_cfg,
    input  logic [rls_pkg::CNT_W-1:0]     i_count,
    input  logic [rls_pkg::ENTRY_W-1:0]   i_word,
    output rls_pkg::t_send_stat           o_stat
);
    import rls_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SEND = 3'b010,
        PH_GAP  = 3'b100
    } t_phase;

    localparam logic [BITPOS_W-1:0] LAST_BIT = BITPOS_W'(ENTRY_W - 1);

    t_phase              r_phase,  n_phase;
    logic                r_line,   n_line;
    logic [CNT_W-1:0]    r_ptr,    n_ptr;
    logic [ENTRY_W-1:0]  r_shift,  n_shift;
    logic [BITPOS_W-1:0] r_bitpos, n_bitpos;
    logic [TICK_W-1:0]   r_cell,   n_cell;
    logic [LATCH_W-1:0]  r_gap,    n_gap;

    logic [TICK_W-1:0]   period;
    logic [TICK_W-1:0]   high_len;
    logic [LATCH_W-1:0]  gap_len;
    logic [TICK_W:0]     cell_inc;
    logic [LATCH_W:0]    gap_inc;
    logic [CNT_W-1:0]    ptr_inc;

    always_comb begin
        period   = (i_cfg.bit_period == '0) ? TICK_W'(1) : i_cfg.bit_period;
        gap_len  = (i_cfg.latch == '0) ? LATCH_W'(1) : i_cfg.latch;
        high_len = r_shift[ENTRY_W-1] ? i_cfg.one_high : i_cfg.zero_high;
        cell_inc = {1'b0, r_cell} + (TICK_W+1)'(1);
        gap_inc  = {1'b0, r_gap} + (LATCH_W+1)'(1);
        ptr_inc  = r_ptr + CNT_W'(1);

        n_phase  = r_phase;
        n_line   = r_line;
        n_ptr    = r_ptr;
        n_shift  = r_shift;
        n_bitpos = r_bitpos;
        n_cell   = r_cell;
        n_gap    = r_gap;

        if (i_cmd.load) begin
            n_ptr = '0;
            if (i_count != '0) begin
                n_shift  = i_word;
                n_bitpos = '0;
                n_cell   = '0;
                n_phase  = PH_SEND;
            end else begin
                n_gap   = '0;
                n_phase = PH_GAP;
            end
        end else if (i_cmd.tick) begin
            case (r_phase)
                PH_SEND: begin
                    n_line = (r_cell < high_len);
                    if (cell_inc >= {1'b0, period}) begin
                        n_cell  = '0;
                        n_shift = {r_shift[ENTRY_W-2:0], 1'b0};
                        if (r_bitpos == LAST_BIT) begin
                            n_bitpos = '0;
                            n_ptr    = ptr_inc;
                            if (ptr_inc < i_count) begin
                                // next entry was prefetched at ptr + 1
                                n_shift = i_word;
                            end else begin
                                n_gap   = '0;
                                n_phase = PH_GAP;
                            end
                        end else begin
                            n_bitpos = r_bitpos + BITPOS_W'(1);
                        end
                    end else begin
                        n_cell = cell_inc[TICK_W-1:0];
                    end
                end
                PH_GAP: begin
                    n_line = 1'b0;
                    if (gap_inc >= {1'b0, gap_len}) begin
                        n_gap   = '0;
                        n_phase = PH_IDLE;
                    end else begin
                        n_gap = gap_inc[LATCH_W-1:0];
                    end
                end
                default: begin
                    n_line  = 1'b0;
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_line   <= 1'b0;
            r_ptr    <= '0;
            r_shift  <= '0;
            r_bitpos <= '0;
            r_cell   <= '0;
            r_gap    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_line   <= n_line;
            r_ptr    <= n_ptr;
            r_shift  <= n_shift;
            r_bitpos <= n_bitpos;
            r_cell   <= n_cell;
            r_gap    <= n_gap;
        end
    end

    assign o_stat.busy = (r_phase != PH_IDLE);
    assign o_stat.line = r_line;
    assign o_stat.ptr  = r_ptr;

endmodule
